FILE: rtl/fcs_pkg.sv
package fcs_pkg;

  localparam logic [15:0] SumInit = 16'hffff;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;
  } fcs_item_t;

  // 16-bit add with end-around carry
  function automatic logic [15:0] add_eac(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

FILE: rtl/fletcher32_checksum.sv
// Fletcher-32 over a byte stream: bytes pair big-endian into 16-bit words, both
// sums start at 0xffff and add with end-around carry. One byte is taken every
// cycle unless the output stalls; an item passes an input register and then the
// sum/result register, where the checksum of the item carrying last_byte is held.
// An item with last_byte and no byte closes the message; an odd final byte is
// padded with a zero low byte. The sums return to 0xffff after every checksum.
module fletcher32_checksum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] checksum_o
);
  import fcs_pkg::*;

  fcs_item_t in_item, item;
  logic      item_valid, item_take;

  assign in_item.data_byte    = data_byte_i;
  assign in_item.byte_present = byte_present_i;
  assign in_item.last_byte    = last_byte_i;

  fcs_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .item_valid_o(item_valid),
    .item_take_i (item_take),
    .item_o      (item)
  );

  fcs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_take_o (item_take),
    .item_i      (item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .checksum_o  (checksum_o)
  );

endmodule

FILE: rtl/fcs_in_reg.sv
module fcs_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fcs_pkg::fcs_item_t in_item_i,
  output logic              item_valid_o,
  input  logic              item_take_i,
  output fcs_pkg::fcs_item_t item_o
);
  import fcs_pkg::*;

  logic      valid_q, valid_d;
  fcs_item_t item_q;

  assign in_ready_o = !valid_q || item_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload: load on every transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

FILE: rtl/fcs_core.sv
module fcs_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  output logic              item_take_o,
  input  fcs_pkg::fcs_item_t item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       checksum_o
);
  import fcs_pkg::*;

  logic [15:0] first_q, first_d, second_q, second_d;
  logic [15:0] first_new, second_new, word;
  logic [7:0]  held_byte_q;
  logic        held_q, held_d;
  logic        absorb;
  logic        out_valid_q, out_valid_d;
  logic [31:0] checksum_q;

  assign item_take_o = item_valid_i && (!out_valid_q || out_ready_i);

  // at most one word per item: a full pair, or a padded final byte
  always_comb begin
    absorb = (item_i.byte_present && held_q) ||
             (item_i.last_byte && (held_q || item_i.byte_present));
    if (held_q) begin
      word = {held_byte_q, item_i.byte_present ? item_i.data_byte : 8'h00};
    end else begin
      word = {item_i.data_byte, 8'h00};
    end
    first_new  = absorb ? add_eac(first_q, word) : first_q;
    second_new = absorb ? add_eac(second_q, first_new) : second_q;
  end

  always_comb begin
    first_d     = first_q;
    second_d    = second_q;
    held_d      = held_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (item_take_o) begin
      if (item_i.last_byte) begin
        first_d     = SumInit;
        second_d    = SumInit;
        held_d      = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        first_d  = first_new;
        second_d = second_new;
        if (item_i.byte_present) begin
          held_d = !held_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= SumInit;
      second_q    <= SumInit;
      held_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      first_q     <= first_d;
      second_q    <= second_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o && item_i.byte_present && !held_q) begin
      held_byte_q <= item_i.data_byte;
    end
    if (item_take_o && item_i.last_byte) begin
      checksum_q <= {second_new, first_new};
    end
  end

  assign out_valid_o = out_valid_q;
  assign checksum_o  = checksum_q;

endmodule

FILE: bench/fletcher32_checksum_tb.sv
`timescale 1ns / 1ps

module fletcher32_checksum_tb;

  localparam int CycleLimit  = 600000;
  localparam int HoldLen     = 150;
  localparam int DrainCycles = 8;
  localparam int NumRows     = 21;

  // one directed transfer; csum is used only where has_csum is set
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        last_byte;
    logic        has_csum;
    logic [31:0] csum;
  } dir_row_t;

  localparam dir_row_t DirRows [NumRows] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'hffffffff},  // empty message
    '{8'h5a, 1'b0, 1'b0, 1'b0, 32'h0},         // idle transfer
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'hffffffff},  // empty again, idle changed nothing
    '{8'h00, 1'b1, 1'b1, 1'b1, 32'hffffffff},  // lone zero byte, padded
    '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},         // lone 0xff byte, padded
    '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},         // word 0xffff
    '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'hc3, 1'b0, 1'b1, 1'b0, 32'h0},         // close with no byte after a full word
    '{8'h80, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h3c, 1'b0, 1'b0, 1'b0, 32'h0},         // idle while a high byte is held
    '{8'h01, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h55, 1'b1, 1'b1, 1'b0, 32'h0},         // three bytes, odd length
    '{8'h7f, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'hfe, 1'b0, 1'b1, 1'b0, 32'h0},         // close while a byte is held
    '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'hffffffff}   // sums back at 0xffff after a checksum
  };

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i    = 8'h00;
  logic        byte_present_i = 1'b0;
  logic        last_byte_i    = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [31:0] checksum_o;

  // predictor state
  logic [15:0] sum_a;
  logic [15:0] sum_b;
  logic [7:0]  pend_byte;
  logic        pend_valid;

  logic [31:0] csum_q [$];

  int error_count   = 0;
  int cycle_count   = 0;
  int items_sent    = 0;
  int msgs_sent     = 0;
  int csums_checked = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;

  fletcher32_checksum u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .byte_present_i(byte_present_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .checksum_o    (checksum_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? s[15:0] + 16'd1 : s[15:0];
  endfunction

  function automatic void fold_word(input logic [15:0] w);
    sum_a = ones_add(sum_a, w);
    sum_b = ones_add(sum_b, sum_a);
  endfunction

  function automatic void clear_sums();
    sum_a      = 16'hffff;
    sum_b      = 16'hffff;
    pend_byte  = 8'h00;
    pend_valid = 1'b0;
  endfunction

  // advance the predictor by one transfer; returns 1 when a checksum is due
  function automatic bit fletcher_step(input logic [7:0] b, input logic p, input logic l,
                                       output logic [31:0] csum);
    csum = 32'h0;
    if (p) begin
      if (pend_valid) begin
        fold_word({pend_byte, b});
        pend_valid = 1'b0;
      end else begin
        pend_byte  = b;
        pend_valid = 1'b1;
      end
    end
    if (!l) return 1'b0;
    if (pend_valid) fold_word({pend_byte, 8'h00});
    csum = {sum_b, sum_a};
    clear_sums();
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // offer one transfer; typed_csum overrides the predicted checksum when use_typed is set
  task automatic send_item(input logic [7:0] b, input logic p, input logic l,
                           input bit use_typed = 1'b0, input logic [31:0] typed_csum = 32'h0);
    logic [31:0] pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    byte_present_i <= p;
    last_byte_i    <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (fletcher_step(b, p, l, pred)) begin
      csum_q.push_back(use_typed ? typed_csum : pred);
      msgs_sent++;
    end
    if (p || l) items_sent++;
  endtask

  task automatic send_message(input int nbytes);
    bit split_close;
    split_close = (nbytes == 0) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 99) < 8) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(pick_byte(), 1'b1, !split_close && (i == nbytes - 1));
    end
    if (split_close) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct, input int n_items);
    int target;
    send_idle_pct = snd_pct;
    recv_idle_pct <= rcv_pct;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(0, 19) == 0) send_message($urandom_range(30, 90));
      else send_message($urandom_range(0, 16));
    end
  endtask

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HoldLen;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : csum_check
    logic [31:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (csum_q.size() == 0) begin
        $error("checksum: no transfer pending, actual %h", checksum_o);
        error_count++;
      end else begin
        want = csum_q.pop_front();
        csums_checked++;
        if (checksum_o !== want) begin
          $error("checksum: expected %h, actual %h", want, checksum_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    clear_sums();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 13;
    recv_idle_pct <= 74;
    for (int r = 0; r < NumRows; r++) begin
      send_item(DirRows[r].data_byte, DirRows[r].byte_present, DirRows[r].last_byte,
                DirRows[r].has_csum, DirRows[r].csum);
    end

    run_phase(13, 74, 600);
    run_phase(74, 13, 600);
    run_phase(0, 0, 600);

    // hold the receiver off while short messages keep coming, so the block backs up
    hold_req <= hold_req + 1;
    for (int k = 0; k < 30; k++) send_item(pick_byte(), 1'b1, 1'b1);

    in_valid_i <= 1'b0;
    while (csum_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (csum_q.size() != 0) begin
      $error("checksum: %0d expected results never arrived", csum_q.size());
      error_count++;
    end

    $display("Run covered %0d byte/close transfers in %0d messages, %0d checksums compared,",
             items_sent, msgs_sent, csums_checked);
    $display("with sender and receiver stalls swapped and a %0d-cycle receiver hold-off.",
             HoldLen);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
